// ----- src/dwm_pkg.sv -----
// Shared types and constants for the drowsiness window monitor.
// No dependencies; compiled first.
`default_nettype none

package dwm_pkg;

  localparam int AR_W     = 16;  // eye aspect ratio, Q0.16
  localparam int RATIO_W  = 17;  // closed fraction, Q1.16
  localparam int FRAC_W   = 16;  // fraction bits of the quotient
  localparam int DROP_W   = 8;   // head drop counter
  localparam int STEP_W   = 14;
  localparam int STEADY_W = 15;
  localparam int WIN_W    = 16;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_EYE_THR    = 3'd0,
    REG_RATIO_THR  = 3'd1,
    REG_WINDOW_MS  = 3'd2,
    REG_DROP_STEP  = 3'd3,
    REG_STEADY_LIM = 3'd4,
    REG_MAX_DOWN   = 3'd5
  } cfg_reg_t;

  localparam logic [AR_W-1:0]     RST_EYE_THR    = 16'd19661;
  localparam logic [RATIO_W-1:0]  RST_RATIO_THR  = 17'd39322;
  localparam logic [WIN_W-1:0]    RST_WINDOW_MS  = 16'd2000;
  localparam logic [STEP_W-1:0]   RST_DROP_STEP  = 14'd8;
  localparam logic [STEADY_W-1:0] RST_STEADY_LIM = 15'd1;
  localparam logic [DROP_W-1:0]   RST_MAX_DOWN   = 8'd5;

  typedef struct packed {
    logic [AR_W-1:0]            ear_threshold;
    logic [RATIO_W-1:0]         ratio_threshold;
    logic [WIN_W-1:0]           window_ms;
    logic [STEP_W-1:0]          drop_step;
    logic signed [STEADY_W-1:0] steady_limit;
    logic [DROP_W-1:0]          max_down;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // capture input word
    logic calc;        // eye compare, nose step, overflow flag
    logic pop;         // drop oldest ring entry
    logic append;      // write new ring entry
    logic div_start;   // launch fraction divide
    logic hold_ratio;  // store quotient
    logic out_load;    // fill output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic face;
    logic full;
    logic evict;
    logic div_busy;
  } dp_sts_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CALC   = 8'b0000_0010,
    S_APPEND = 8'b0000_0100,
    S_START  = 8'b0000_1000,
    S_EVCHK  = 8'b0001_0000,
    S_EVRD   = 8'b0010_0000,
    S_WAIT   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ----- src/dwm_if.sv -----
// Valid/ready channel interfaces for the frame input and the result output.
// Depends on dwm_pkg.
`default_nettype none

interface dwm_in_if
  import dwm_pkg::*;
#(
  parameter int STAMP_BITS = 32,
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] stamp_ms;
  logic                  face_present;
  logic [AR_W-1:0]       ear_left;
  logic [AR_W-1:0]       ear_right;
  logic [COORD_BITS-1:0] nose_y_a;
  logic [COORD_BITS-1:0] nose_y_b;
  logic [COORD_BITS-1:0] nose_y_c;
  logic [COORD_BITS-1:0] nose_y_d;

  modport source (output valid, stamp_ms, face_present, ear_left, ear_right,
                  nose_y_a, nose_y_b, nose_y_c, nose_y_d, input ready);
  modport sink   (input valid, stamp_ms, face_present, ear_left, ear_right,
                  nose_y_a, nose_y_b, nose_y_c, nose_y_d, output ready);
endinterface

interface dwm_out_if
  import dwm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               eye_closed;
  logic [RATIO_W-1:0] closed_fraction;
  logic               sleeping;
  logic [DROP_W-1:0]  drop_count;
  logic               head_dropped;
  logic               window_overflow;

  modport source (output valid, eye_closed, closed_fraction, sleeping, drop_count,
                  head_dropped, window_overflow, input ready);
  modport sink   (input valid, eye_closed, closed_fraction, sleeping, drop_count,
                  head_dropped, window_overflow, output ready);
endinterface

`default_nettype wire

// ----- src/dwm_div.sv -----
// Bit-serial divider for the closed fraction: num * 2^16 / den, num <= den.
// Depends on dwm_pkg. One quotient bit per cycle.
`default_nettype none

module dwm_div
  import dwm_pkg::*;
#(
  parameter int CNT_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [CNT_W-1:0]   num,
  input  wire logic [CNT_W-1:0]   den,
  output      logic               busy,
  output      logic [RATIO_W-1:0] quo
);

  localparam int STEP_CW = $clog2(FRAC_W + 1);

  logic               busy_r, busy_nxt;
  logic [STEP_CW-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   den_r, den_nxt;
  logic [RATIO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W:0]     rem2;
  logic               ge;

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      den_nxt  = den;
      // integer bit: only set when every entry is closed
      if (num >= den) begin
        rem_nxt = num - den;
        quo_nxt = RATIO_W'(1);
      end else begin
        rem_nxt = num;
        quo_nxt = '0;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(rem2 - {1'b0, den_r}) : CNT_W'(rem2);
      quo_nxt  = {quo_r[RATIO_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_CW'(FRAC_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

// ----- src/dwm_dp.sv -----
// Datapath: input capture, eye/nose logic, window ring memory and counts,
// divider, output register. Depends on dwm_pkg and dwm_div.
`default_nettype none

module dwm_dp
  import dwm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 128,
  parameter int STAMP_BITS   = 32,
  parameter int COORD_BITS   = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire dp_cmd_t               cmd,
  output      dp_sts_t               sts,
  input  wire logic [STAMP_BITS-1:0] in_stamp_ms,
  input  wire logic                  in_face_present,
  input  wire logic [AR_W-1:0]       in_ear_left,
  input  wire logic [AR_W-1:0]       in_ear_right,
  input  wire logic [COORD_BITS-1:0] in_nose_y_a,
  input  wire logic [COORD_BITS-1:0] in_nose_y_b,
  input  wire logic [COORD_BITS-1:0] in_nose_y_c,
  input  wire logic [COORD_BITS-1:0] in_nose_y_d,
  output      logic                  out_eye_closed,
  output      logic [RATIO_W-1:0]    out_closed_fraction,
  output      logic                  out_sleeping,
  output      logic [DROP_W-1:0]     out_drop_count,
  output      logic                  out_head_dropped,
  output      logic                  out_window_overflow
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = COORD_BITS + 2;
  localparam int DIFF_W = (SUM_W + 1 > STEADY_W + 1) ? SUM_W + 1 : STEADY_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);

  // captured input word
  logic [STAMP_BITS-1:0] stamp_r;
  logic                  face_r;
  logic [AR_W-1:0]       left_r, right_r;
  logic [COORD_BITS-1:0] ny_a_r, ny_b_r, ny_c_r, ny_d_r;

  // frame flags and persistent state
  logic                  closed_r, ovf_r;
  logic [SUM_W-1:0]      prev_sum_r;
  logic                  prev_valid_r;
  logic [DROP_W-1:0]     down_r;
  logic [IDX_W-1:0]      oldest_r;
  logic [CNT_W-1:0]      count_r, ccount_r;
  logic [RATIO_W-1:0]    ratio_held_r;

  // ring: {closed, stamp}
  logic [STAMP_BITS:0]   win_mem [WINDOW_DEPTH];
  logic [STAMP_BITS:0]   rd_r;

  logic [SUM_W-1:0]         nose_sum;
  logic signed [DIFF_W-1:0] diff, step_s, steady_s;
  logic [AR_W:0]            pair_sum;
  logic                     closed_now;
  logic                     full;
  logic [IDX_W-1:0]         oldest_inc;
  logic [CNT_W:0]           slot_sum, slot_wrap;
  logic [IDX_W-1:0]         slot;
  logic [STAMP_BITS-1:0]    age;
  logic                     div_busy;
  logic [RATIO_W-1:0]       div_quo;

  assign nose_sum = SUM_W'(ny_a_r) + SUM_W'(ny_b_r) + SUM_W'(ny_c_r) + SUM_W'(ny_d_r);
  assign diff     = $signed(DIFF_W'(nose_sum)) - $signed(DIFF_W'(prev_sum_r));
  assign step_s   = $signed(DIFF_W'(cfg.drop_step));
  assign steady_s = DIFF_W'(cfg.steady_limit);

  // mean below threshold, checked as sum < 2 * threshold
  assign pair_sum   = {1'b0, left_r} + {1'b0, right_r};
  assign closed_now = pair_sum < {cfg.ear_threshold, 1'b0};

  assign full       = count_r == DEPTH_C;
  assign oldest_inc = (oldest_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_r + 1'b1;
  assign slot_sum   = (CNT_W + 1)'(oldest_r) + (CNT_W + 1)'(count_r);
  assign slot_wrap  = (slot_sum >= (CNT_W + 1)'(WINDOW_DEPTH)) ?
                      slot_sum - (CNT_W + 1)'(WINDOW_DEPTH) : slot_sum;
  assign slot       = slot_wrap[IDX_W-1:0];

  assign age = stamp_r - rd_r[STAMP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      stamp_r <= in_stamp_ms;
      face_r  <= in_face_present;
      left_r  <= in_ear_left;
      right_r <= in_ear_right;
      ny_a_r  <= in_nose_y_a;
      ny_b_r  <= in_nose_y_b;
      ny_c_r  <= in_nose_y_c;
      ny_d_r  <= in_nose_y_d;
    end
    if (cmd.calc) begin
      closed_r <= face_r & closed_now;
      ovf_r    <= face_r & full;
    end
  end

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      win_mem[slot] <= {closed_r, stamp_r};
    end
    rd_r <= win_mem[oldest_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_sum_r   <= '0;
      prev_valid_r <= 1'b0;
      down_r       <= '0;
      oldest_r     <= '0;
      count_r      <= '0;
      ccount_r     <= '0;
      ratio_held_r <= '0;
    end else begin
      if (cmd.calc && face_r) begin
        if (!prev_valid_r) begin
          down_r <= '0;
        end else if (diff >= step_s) begin
          if (down_r != {DROP_W{1'b1}}) begin
            down_r <= down_r + 1'b1;
          end
        end else if (diff < steady_s) begin
          down_r <= '0;
        end
        prev_sum_r   <= nose_sum;
        prev_valid_r <= 1'b1;
      end
      if (cmd.pop) begin
        if (rd_r[STAMP_BITS] && ccount_r != '0) begin
          ccount_r <= ccount_r - 1'b1;
        end
        oldest_r <= oldest_inc;
        count_r  <= count_r - 1'b1;
      end else if (cmd.append) begin
        count_r  <= count_r + 1'b1;
        ccount_r <= ccount_r + CNT_W'(closed_r);
      end
      if (cmd.hold_ratio) begin
        ratio_held_r <= div_quo;
      end
    end
  end

  dwm_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (ccount_r),
    .den   (count_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_eye_closed      <= closed_r;
      out_closed_fraction <= ratio_held_r;
      out_sleeping        <= ratio_held_r >= cfg.ratio_threshold;
      out_drop_count      <= down_r;
      out_head_dropped    <= down_r >= cfg.max_down;
      out_window_overflow <= ovf_r;
    end
  end

  always_comb begin
    sts.face     = face_r;
    sts.full     = full;
    sts.evict    = age > STAMP_BITS'(cfg.window_ms);
    sts.div_busy = div_busy;
  end

endmodule

`default_nettype wire

// ----- src/dwm_ctrl.sv -----
// Frame sequencer and output handshake for the drowsiness window monitor.
// Depends on dwm_pkg.
`default_nettype none

module dwm_ctrl
  import dwm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output      logic    in_ready,
  output      logic    out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output      dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        cmd.pop   = sts.face & sts.full;  // full ring: drop oldest first
        state_nxt = sts.face ? S_APPEND : S_DONE;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_START;
      end
      S_START: begin
        // counts include the appended entry here; read of oldest entry in flight
        cmd.div_start = 1'b1;
        state_nxt     = S_EVCHK;
      end
      S_EVCHK: begin
        if (sts.evict) begin
          cmd.pop   = 1'b1;
          state_nxt = S_EVRD;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_EVRD: begin
        state_nxt = S_EVCHK;
      end
      S_WAIT: begin
        if (!sts.div_busy) begin
          cmd.hold_ratio = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- src/drowsiness_window_monitor.sv -----
// Top level: eye-closure ratio and head-drop monitor, one word per frame.
// Depends on dwm_pkg, dwm_if, dwm_dp (with dwm_div) and dwm_ctrl.
//
// Usage:
//  - in_ch takes one frame word (stamp, face flag, two eye ratios, four nose
//    heights); out_ch returns exactly one result word per frame word.
//  - Handshake on both channels: a word moves on a clock edge with valid and
//    ready high. in_ch.ready is high only while the sequencer is idle, so
//    one frame is in work at a time.
//  - After accept, a frame without a face goes from the calc step straight to
//    the output register. With a face the entry is appended and the
//    bit-serial fraction divider started; then ring entries that age out on
//    that frame are evicted one at a time over the ring memory's single read
//    port, and the result is loaded once both the walk and the divide end.
//  - The result sits in an output register; the next frame word is taken
//    while it waits. A stalled receiver holds the result stable and only
//    stops the sequencer at its final step.
//  - Reset (rst_n low, synchronous) empties the window, clears the drop
//    counter, nose history and held fraction, and loads register defaults.
//    The ring memory itself is not cleared; only written entries are read.
//  - Configuration is APB: registers at byte address 4*i, written in the
//    access phase, read back zero-extended. Write only while idle.
`default_nettype none

module drowsiness_window_monitor
  import dwm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 128,
  parameter int STAMP_BITS   = 32,
  parameter int COORD_BITS   = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dwm_in_if.sink                 in_ch,
  dwm_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output      logic [CFG_DW-1:0] cfg_prdata,
  output      logic              cfg_pready
);

  cfg_t     cfg_r;
  cfg_reg_t reg_sel;
  logic     cfg_wr;
  dp_cmd_t  cmd;
  dp_sts_t  sts;
  logic     in_ready;
  logic     out_valid;

  // ---------------- configuration registers ----------------
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_reg_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ear_threshold   <= RST_EYE_THR;
      cfg_r.ratio_threshold <= RST_RATIO_THR;
      cfg_r.window_ms       <= RST_WINDOW_MS;
      cfg_r.drop_step       <= RST_DROP_STEP;
      cfg_r.steady_limit    <= RST_STEADY_LIM;
      cfg_r.max_down        <= RST_MAX_DOWN;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_EYE_THR:    cfg_r.ear_threshold   <= cfg_pwdata[AR_W-1:0];
        REG_RATIO_THR:  cfg_r.ratio_threshold <= cfg_pwdata[RATIO_W-1:0];
        REG_WINDOW_MS:  cfg_r.window_ms       <= cfg_pwdata[WIN_W-1:0];
        REG_DROP_STEP:  cfg_r.drop_step       <= cfg_pwdata[STEP_W-1:0];
        REG_STEADY_LIM: cfg_r.steady_limit    <= cfg_pwdata[STEADY_W-1:0];
        REG_MAX_DOWN:   cfg_r.max_down        <= cfg_pwdata[DROP_W-1:0];
        default: ;  // unmapped words are ignored
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_EYE_THR:    cfg_prdata = CFG_DW'(cfg_r.ear_threshold);
      REG_RATIO_THR:  cfg_prdata = CFG_DW'(cfg_r.ratio_threshold);
      REG_WINDOW_MS:  cfg_prdata = CFG_DW'(cfg_r.window_ms);
      REG_DROP_STEP:  cfg_prdata = CFG_DW'(cfg_r.drop_step);
      REG_STEADY_LIM: cfg_prdata = CFG_DW'(unsigned'(cfg_r.steady_limit));
      REG_MAX_DOWN:   cfg_prdata = CFG_DW'(cfg_r.max_down);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  dwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // ---------------- datapath ----------------
  dwm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .STAMP_BITS   (STAMP_BITS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_stamp_ms         (in_ch.stamp_ms),
    .in_face_present     (in_ch.face_present),
    .in_ear_left         (in_ch.ear_left),
    .in_ear_right        (in_ch.ear_right),
    .in_nose_y_a         (in_ch.nose_y_a),
    .in_nose_y_b         (in_ch.nose_y_b),
    .in_nose_y_c         (in_ch.nose_y_c),
    .in_nose_y_d         (in_ch.nose_y_d),
    .out_eye_closed      (out_ch.eye_closed),
    .out_closed_fraction (out_ch.closed_fraction),
    .out_sleeping        (out_ch.sleeping),
    .out_drop_count      (out_ch.drop_count),
    .out_head_dropped    (out_ch.head_dropped),
    .out_window_overflow (out_ch.window_overflow)
  );

endmodule

`default_nettype wire

// ----- src/dwm_chk.sv -----
// Port-level checks for drowsiness_window_monitor, attached by bind.
// Depends on dwm_pkg and the top level's port names.
`default_nettype none

module dwm_chk
  import dwm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [RATIO_W-1:0] closed_fraction,
  input wire logic [DROP_W-1:0]  drop_count,
  input wire logic               eye_closed
);

  // one frame in work at a time
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // fraction never exceeds 1.0
  a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && closed_fraction[RATIO_W-1] |-> closed_fraction[RATIO_W-2:0] == '0)
    else $error("closed fraction above one");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(closed_fraction) && $stable(drop_count) && $stable(eye_closed))
    else $error("result changed while stalled");

endmodule

bind drowsiness_window_monitor dwm_chk u_dwm_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .closed_fraction (out_ch.closed_fraction),
  .drop_count      (out_ch.drop_count),
  .eye_closed      (out_ch.eye_closed)
);

`default_nettype wire
